[hdl/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared command codes, phase numbers and the queued item type.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	typedef enum logic [2:0] {
		CMD_IDLE   = 3'd0,
		CMD_START  = 3'd1,
		CMD_STOP   = 3'd2,
		CMD_REPEAT = 3'd3,
		CMD_WRITE  = 3'd4,
		CMD_READ   = 3'd5
	} cmd_t;

	// Phase numbers of the byte commands.
	localparam logic [4:0] WR_ACK_RELEASE = 5'd24;
	localparam logic [4:0] WR_ACK_CLOCK   = 5'd25;
	localparam logic [4:0] RD_BITS_LAST   = 5'd16;
	localparam logic [4:0] RD_ACK_SET     = 5'd17;
	localparam logic [4:0] RD_ACK_CLOCK   = 5'd18;
	localparam int         MSB_BIT        = 7;

	// Classified tick as it travels from the front to the back.
	typedef struct packed {
		logic       launch;
		cmd_t       cmd;
		logic [7:0] write_byte;
		logic       send_nack;
		logic       sda_level;
	} item_t;

endpackage

[hdl/i2c_master_bit_engine.sv]
// An accepted item waits in the queue and then has its result in the output stage.
// Throughput: one item per cycle while results are taken; the engine state updates per item.
// A two-entry queue and the output register let either side stall on its own.
// Reset (arst_n low, asynchronous) empties queue and output stage and puts the engine idle
// with both bus lines released.
// ----------------------------------------------------------------------------
// I2C master bit engine
// Open-drain I2C master that runs one bus phase per input item.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // write_byte[7:0], send_nack[8], sda_level[9], zero[15:10]
	input  logic [2:0]  s_tuser,  // command[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // scl_pull_low[0], sda_pull_low[1], busy_res[2],
	                              // read_data[10:3], ack_level[11], zero[15:12]
	output logic        m_tlast   // done_res
);
	import i2cm_pkg::*;

	item_t      front_item;
	item_t      queue_item;
	logic       queue_full;
	logic       queue_valid;
	logic       queue_pop;
	logic       scl_pull_low;
	logic       sda_pull_low;
	logic       busy_res;
	logic [7:0] read_data;
	logic       ack_level;

	assign s_tready = !queue_full;

	i2cm_front u_front (
		.command    (s_tuser),
		.write_byte (s_tdata[7:0]),
		.send_nack  (s_tdata[8]),
		.sda_level  (s_tdata[9]),
		.item       (front_item)
	);

	i2cm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid && s_tready),
		.push_item (front_item),
		.full      (queue_full),
		.pop       (queue_pop),
		.not_empty (queue_valid),
		.pop_item  (queue_item)
	);

	i2cm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (queue_valid),
		.item         (queue_item),
		.pop          (queue_pop),
		.res_valid    (m_tvalid),
		.res_ready    (m_tready),
		.scl_pull_low (scl_pull_low),
		.sda_pull_low (sda_pull_low),
		.busy_res     (busy_res),
		.done_res     (m_tlast),
		.read_data    (read_data),
		.ack_level    (ack_level)
	);

	assign m_tdata = {4'd0, ack_level, read_data, busy_res, sda_pull_low, scl_pull_low};

endmodule

[hdl/i2cm_front.sv]
// ----------------------------------------------------------------------------
// I2C master front
// Decodes the command of each incoming tick into a launch flag and a command.
// ----------------------------------------------------------------------------
module i2cm_front (
	input  logic [2:0]    command,
	input  logic [7:0]    write_byte,
	input  logic          send_nack,
	input  logic          sda_level,
	output i2cm_pkg::item_t item
);
	import i2cm_pkg::*;

	always_comb begin
		item.write_byte = write_byte;
		item.send_nack  = send_nack;
		item.sda_level  = sda_level;
		case (command)
			CMD_START, CMD_STOP, CMD_REPEAT, CMD_WRITE, CMD_READ: begin
				item.launch = 1'b1;
				item.cmd    = cmd_t'(command);
			end
			default: begin
				// Continue and unused codes only advance a running command.
				item.launch = 1'b0;
				item.cmd    = CMD_IDLE;
			end
		endcase
	end

endmodule

[hdl/i2cm_queue.sv]
// ----------------------------------------------------------------------------
// I2C master item queue
// Two-entry FIFO that decouples the front from the phase engine.
// ----------------------------------------------------------------------------
module i2cm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  i2cm_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output i2cm_pkg::item_t pop_item
);
	import i2cm_pkg::*;

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[hdl/i2cm_back.sv]
// ----------------------------------------------------------------------------
// I2C master phase engine
// Runs one bus phase per queued item and holds the result in an output stage.
// ----------------------------------------------------------------------------
module i2cm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  i2cm_pkg::item_t item,
	output logic            pop,
	output logic            res_valid,
	input  logic            res_ready,
	output logic            scl_pull_low,
	output logic            sda_pull_low,
	output logic            busy_res,
	output logic            done_res,
	output logic [7:0]      read_data,
	output logic            ack_level
);
	import i2cm_pkg::*;

	cmd_t       state_q, state_d;
	logic [4:0] phase_q, phase_d;
	logic [1:0] sub_q, sub_d;
	logic [7:0] shift_q, shift_d;
	logic       nack_q, nack_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       ack_q, ack_d;

	logic       launch;
	cmd_t       cur;
	logic [4:0] p;
	logic [1:0] sub;
	logic       last;

	assign pop = item_valid && (!res_valid || res_ready);

	always_comb begin
		launch  = (state_q == CMD_IDLE) && item.launch;
		cur     = launch ? item.cmd : state_q;
		p       = launch ? 5'd0 : phase_q;
		sub     = launch ? 2'd0 : sub_q;
		shift_d = (launch && item.cmd == CMD_WRITE) ? item.write_byte : shift_q;
		nack_d  = (launch && item.cmd == CMD_READ) ? item.send_nack : nack_q;
		sub_d   = sub;
		scl_d   = scl_q;
		sda_d   = sda_q;
		ack_d   = ack_q;
		last    = 1'b0;
		case (cur)
			CMD_START: begin
				if (p == 5'd0) begin
					sda_d = 1'b1;
				end else begin
					scl_d = 1'b1;
					last  = 1'b1;
				end
			end
			CMD_STOP: begin
				if (p == 5'd0) begin
					sda_d = 1'b1;
				end else if (p == 5'd1) begin
					scl_d = 1'b0;
				end else begin
					sda_d = 1'b0;
					last  = 1'b1;
				end
			end
			CMD_REPEAT: begin
				if (p == 5'd0) begin
					sda_d = 1'b0;
				end else if (p == 5'd1) begin
					scl_d = 1'b0;
				end else if (p == 5'd2) begin
					sda_d = 1'b1;
				end else begin
					scl_d = 1'b1;
					last  = 1'b1;
				end
			end
			CMD_WRITE: begin
				if (p < WR_ACK_RELEASE) begin
					// Each data bit takes three phases: set SDA, raise SCL, drop SCL.
					sub_d = (sub == 2'd2) ? 2'd0 : sub + 2'd1;
					if (sub == 2'd0) begin
						sda_d = ~shift_d[MSB_BIT];
					end else if (sub == 2'd1) begin
						scl_d = 1'b0;
					end else begin
						scl_d   = 1'b1;
						shift_d = {shift_d[6:0], 1'b0};
					end
				end else if (p == WR_ACK_RELEASE) begin
					sda_d = 1'b0;
				end else if (p == WR_ACK_CLOCK) begin
					scl_d = 1'b0;
				end else begin
					ack_d = item.sda_level;
					scl_d = 1'b1;
					last  = 1'b1;
				end
			end
			CMD_READ: begin
				if (p == 5'd0) begin
					sda_d   = 1'b0;
					shift_d = 8'd0;
				end else if (p <= RD_BITS_LAST) begin
					if (p[0]) begin
						scl_d = 1'b0;
					end else begin
						// The bit is taken from the level seen before SCL falls.
						shift_d = {shift_d[6:0], item.sda_level};
						scl_d   = 1'b1;
					end
				end else if (p == RD_ACK_SET) begin
					sda_d = ~nack_d;
				end else if (p == RD_ACK_CLOCK) begin
					scl_d = 1'b0;
				end else begin
					scl_d = 1'b1;
					last  = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (cur == CMD_IDLE || last) begin
			state_d = CMD_IDLE;
			phase_d = 5'd0;
		end else begin
			state_d = cur;
			phase_d = p + 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CMD_IDLE;
			phase_q <= 5'd0;
			sub_q   <= 2'd0;
			shift_q <= 8'd0;
			nack_q  <= 1'b0;
			scl_q   <= 1'b0;
			sda_q   <= 1'b0;
			ack_q   <= 1'b0;
		end else if (pop) begin
			state_q <= state_d;
			phase_q <= phase_d;
			sub_q   <= sub_d;
			shift_q <= shift_d;
			nack_q  <= nack_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			ack_q   <= ack_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (pop) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			scl_pull_low <= scl_d;
			sda_pull_low <= sda_d;
			busy_res     <= (cur != CMD_IDLE) && !last;
			done_res     <= last;
			read_data    <= (last && cur == CMD_READ) ? shift_d : 8'd0;
			ack_level    <= (last && cur == CMD_WRITE) ? ack_d : 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_idle_phase_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CMD_IDLE) |-> (phase_q == 5'd0))
		else $error("phase count nonzero while idle");

	// The write acknowledge sample, the phase after WR_ACK_CLOCK, is the last phase of the longest command.
	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= (WR_ACK_CLOCK + 5'd1))
		else $error("phase count beyond longest command");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(done_res && busy_res))
		else $error("result both done and busy");

	a_data_only_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !done_res) |-> (read_data == 8'd0 && !ack_level))
		else $error("read data or ack shown without done");
`endif

endmodule

[test/i2c_master_bit_engine_test.sv]
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives bus phase ticks over the input stream. A directed table runs first,
// then random transactions of start, byte transfers, repeated start and stop,
// mixed with idle noise. Results not pinned in the table are checked against
// a behavioral model of the phase engine kept inside the bench. Both stream
// sides idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cm_pkg::*;

	localparam logic [2:0] CODE_SPARE_LO = 3'd6;
	localparam logic [2:0] CODE_SPARE_HI = 3'd7;
	localparam int         RANDOM_TICKS  = 1000;
	localparam int         CYCLE_LIMIT   = 500000;
	localparam int         HOLD_CYCLES   = 400;
	localparam int         TAIL_CYCLES   = 20;

	// Result layout on m_tdata, lowest field last.
	typedef struct packed {
		logic       ack;
		logic [7:0] rdata;
		logic       busy;
		logic       sda;
		logic       scl;
	} bus_word_t;

	typedef struct packed {
		logic      done;
		bus_word_t word;
	} tick_result_t;

	typedef struct packed {
		logic [2:0]   cmd;
		logic [7:0]   wbyte;
		logic         nack;
		logic         sda;
		logic         run_out;  // repeat the same item until the command ends
		logic         pinned;   // use the typed result instead of the model
		tick_result_t pin;
	} plan_row_t;

	localparam tick_result_t NONE = '0;

	localparam int PLAN_LEN = 17;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{CMD_IDLE,      8'h00, 1'b0, 1'b0, 1'b0, 1'b1, NONE},
		'{CODE_SPARE_LO, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, NONE},
		'{CODE_SPARE_HI, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, NONE},
		'{CMD_START,     8'h00, 1'b0, 1'b0, 1'b0, 1'b1, '{1'b0, '{1'b0, 8'h00, 1'b1, 1'b1, 1'b0}}},
		// A stop offered while the start is running is ignored.
		'{CMD_STOP,      8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, '{1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b1}}},
		// Unused code while idle holds both pull levels.
		'{CODE_SPARE_LO, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, '{1'b0, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b1}}},
		'{CMD_WRITE,     8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, NONE},
		'{CMD_WRITE,     8'h00, 1'b0, 1'b1, 1'b1, 1'b0, NONE},
		'{CMD_WRITE,     8'hA5, 1'b1, 1'b0, 1'b1, 1'b0, NONE},
		'{CMD_READ,      8'h00, 1'b0, 1'b1, 1'b1, 1'b0, NONE},
		'{CMD_READ,      8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, NONE},
		'{CMD_REPEAT,    8'h00, 1'b0, 1'b1, 1'b1, 1'b0, NONE},
		'{CMD_WRITE,     8'h5A, 1'b0, 1'b1, 1'b1, 1'b0, NONE},
		'{CMD_STOP,      8'h00, 1'b0, 1'b0, 1'b1, 1'b0, NONE},
		'{CMD_IDLE,      8'h00, 1'b0, 1'b0, 1'b0, 1'b1, NONE},
		'{CMD_READ,      8'h00, 1'b1, 1'b1, 1'b1, 1'b0, NONE},
		'{CMD_STOP,      8'h00, 1'b0, 1'b1, 1'b1, 1'b0, NONE}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [2:0]  s_tuser = CMD_IDLE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	logic        hold_rx = 1'b0;
	int          ticks_sent = 0;
	int          results_seen = 0;
	int          errors = 0;

	tick_result_t pending_ticks[$];

	// Engine model state.
	cmd_t        eng_cmd = CMD_IDLE;
	logic [4:0]  eng_phase = '0;
	logic [7:0]  eng_shift = '0;
	logic        eng_nack = 1'b0;
	logic        eng_scl = 1'b0;
	logic        eng_sda = 1'b0;
	logic        eng_ack = 1'b0;

	i2c_master_bit_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #4 clk = ~clk;

	task automatic advance_bus_model(input logic [2:0] cmd, input logic [7:0] wbyte,
			input logic nack, input logic sda_in, output tick_result_t res);
		logic last;
		res = '0;
		last = 1'b0;
		if (eng_cmd == CMD_IDLE && cmd >= CMD_START && cmd <= CMD_READ) begin
			eng_cmd = cmd_t'(cmd);
			eng_phase = '0;
			if (eng_cmd == CMD_WRITE)
				eng_shift = wbyte;
			if (eng_cmd == CMD_READ)
				eng_nack = nack;
		end
		if (eng_cmd != CMD_IDLE) begin
			case (eng_cmd)
				CMD_START: begin
					if (eng_phase == 0) eng_sda = 1'b1;
					else begin
						eng_scl = 1'b1;
						last = 1'b1;
					end
				end
				CMD_STOP: begin
					if (eng_phase == 0) eng_sda = 1'b1;
					else if (eng_phase == 1) eng_scl = 1'b0;
					else begin
						eng_sda = 1'b0;
						last = 1'b1;
					end
				end
				CMD_REPEAT: begin
					if (eng_phase == 0) eng_sda = 1'b0;
					else if (eng_phase == 1) eng_scl = 1'b0;
					else if (eng_phase == 2) eng_sda = 1'b1;
					else begin
						eng_scl = 1'b1;
						last = 1'b1;
					end
				end
				CMD_WRITE: begin
					if (eng_phase < WR_ACK_RELEASE) begin
						case (eng_phase % 3)
							0: eng_sda = ~eng_shift[MSB_BIT];
							1: eng_scl = 1'b0;
							default: begin
								eng_scl = 1'b1;
								eng_shift = {eng_shift[6:0], 1'b0};
							end
						endcase
					end else if (eng_phase == WR_ACK_RELEASE) eng_sda = 1'b0;
					else if (eng_phase == WR_ACK_CLOCK) eng_scl = 1'b0;
					else begin
						eng_ack = sda_in;
						eng_scl = 1'b1;
						last = 1'b1;
					end
				end
				CMD_READ: begin
					if (eng_phase == 0) begin
						eng_sda = 1'b0;
						eng_shift = '0;
					end else if (eng_phase <= RD_BITS_LAST) begin
						// SDA is taken on the tick that pulls SCL low again.
						if (eng_phase[0]) eng_scl = 1'b0;
						else begin
							eng_shift = {eng_shift[6:0], sda_in};
							eng_scl = 1'b1;
						end
					end else if (eng_phase == RD_ACK_SET) eng_sda = ~eng_nack;
					else if (eng_phase == RD_ACK_CLOCK) eng_scl = 1'b0;
					else begin
						eng_scl = 1'b1;
						last = 1'b1;
					end
				end
				default: last = 1'b1;
			endcase
			if (last) begin
				res.done = 1'b1;
				if (eng_cmd == CMD_READ) res.word.rdata = eng_shift;
				if (eng_cmd == CMD_WRITE) res.word.ack = eng_ack;
				eng_cmd = CMD_IDLE;
				eng_phase = '0;
			end else begin
				res.word.busy = 1'b1;
				eng_phase = eng_phase + 5'd1;
			end
		end
		res.word.scl = eng_scl;
		res.word.sda = eng_sda;
	endtask

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		$display("result %0d: %s expected %0h got %0h", results_seen, what, want, got);
		errors++;
	endtask

	// Sender side: random gap, offer the item, wait for it to be taken.
	bit s_calm = 1'b0;

	task automatic send_tick(input logic [2:0] cmd, input logic [7:0] wbyte,
			input logic nack, input logic sda_in, input logic pinned,
			input tick_result_t pin);
		int gap;
		tick_result_t res;
		if ($urandom_range(0, 39) == 0)
			s_calm = !s_calm;
		gap = s_calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, sda_in, nack, wbyte};
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		ticks_sent++;
		advance_bus_model(cmd, wbyte, nack, sda_in, res);
		pending_ticks.push_back(pinned ? pin : res);
	endtask

	// Issues a command and keeps ticking with random content until it ends.
	task automatic run_command(input logic [2:0] cmd);
		send_tick(cmd, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, NONE);
		while (eng_cmd != CMD_IDLE)
			send_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
				1'($urandom), 1'b0, NONE);
	endtask

	initial begin
		int start_count;
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_LEN; i++) begin
			send_tick(PLAN[i].cmd, PLAN[i].wbyte, PLAN[i].nack, PLAN[i].sda,
				PLAN[i].pinned, PLAN[i].pin);
			if (PLAN[i].run_out)
				while (eng_cmd != CMD_IDLE)
					send_tick(PLAN[i].cmd, PLAN[i].wbyte, PLAN[i].nack, PLAN[i].sda,
						1'b0, NONE);
		end

		start_count = ticks_sent;
		while (ticks_sent - start_count < RANDOM_TICKS) begin
			if ($urandom_range(0, 7) == 0) begin
				// Noise: idle ticks with codes that start nothing.
				n = $urandom_range(1, 3);
				repeat (n) begin
					case ($urandom_range(0, 2))
						0: send_tick(CMD_IDLE, 8'($urandom), 1'($urandom), 1'($urandom),
							1'b0, NONE);
						1: send_tick(CODE_SPARE_LO, 8'($urandom), 1'($urandom),
							1'($urandom), 1'b0, NONE);
						default: send_tick(CODE_SPARE_HI, 8'($urandom), 1'($urandom),
							1'($urandom), 1'b0, NONE);
					endcase
				end
			end else begin
				run_command(CMD_START);
				n = $urandom_range(1, 3);
				repeat (n)
					run_command($urandom_range(0, 1) ? CMD_WRITE : CMD_READ);
				if ($urandom_range(0, 3) == 0) begin
					run_command(CMD_REPEAT);
					run_command(CMD_WRITE);
					run_command(CMD_READ);
				end
				run_command(CMD_STOP);
			end
		end
		s_tvalid <= 1'b0;

		while (pending_ticks.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("i2c_master_bit_engine_test OK");
		else
			$display("i2c_master_bit_engine_test NOT OK");
		$finish;
	end

	// Receiver side with its own random gaps and one long hold-off.
	initial begin
		int gap;
		bit calm;
		tick_result_t want;
		bus_word_t got;
		calm = 1'b0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				calm = !calm;
			gap = calm ? 0 : $urandom_range(0, 11);
			if (gap > 0 || hold_rx) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (hold_rx) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			results_seen++;
			got = m_tdata[11:0];
			if (pending_ticks.size() == 0) begin
				report_mismatch("unexpected result", 0, m_tdata);
			end else begin
				want = pending_ticks.pop_front();
				if (got.scl !== want.word.scl)
					report_mismatch("scl_pull_low", want.word.scl, got.scl);
				if (got.sda !== want.word.sda)
					report_mismatch("sda_pull_low", want.word.sda, got.sda);
				if (got.busy !== want.word.busy)
					report_mismatch("busy", want.word.busy, got.busy);
				if (m_tlast !== want.done)
					report_mismatch("done", want.done, m_tlast);
				if (got.rdata !== want.word.rdata)
					report_mismatch("read_data", want.word.rdata, got.rdata);
				if (got.ack !== want.word.ack)
					report_mismatch("ack_level", want.word.ack, got.ack);
			end
		end
	end

	// Long stall of the result side while the sender keeps offering items.
	initial begin
		wait (ticks_sent >= 300);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("i2c_master_bit_engine_test NOT OK");
		$finish;
	end

endmodule

[sim.f]
hdl/i2cm_pkg.sv
hdl/i2cm_front.sv
hdl/i2cm_queue.sv
hdl/i2cm_back.sv
hdl/i2c_master_bit_engine.sv
test/i2c_master_bit_engine_test.sv
